>>> src/assd_pkg.sv
// Shared constants and types for the start/stop serial receive deframer.
package assd_pkg;

    // Widths of the item fields.
    localparam int unsigned BITS_W  = 8;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned CHAR_W  = 8;

    // Largest number of line bits taken from one item.
    localparam int unsigned MAX_BITS_PER_CALL = 8;

    // One frame: start bit, eight data bits, stop bit.
    localparam int unsigned FRAME_BITS = 10;

    // Queue holds at most nine leftover bits plus one full group.
    localparam int unsigned QUEUE_W = FRAME_BITS - 1 + MAX_BITS_PER_CALL;
    localparam int unsigned PEND_W  = $clog2(QUEUE_W + 1);
    localparam int unsigned IDX_W   = $clog2(BITS_W);

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

endpackage

>>> src/async_start_stop_deframer.sv
// Start/stop serial receive deframer: bit-serial queue fill, idle drop and frame output.
// Operation: an item is taken in the idle state, then each run step appends one line bit
// and drops one idle one from the old end; a last run step decides, and a character goes
// through the emit step into the result register, which stalls while that register is full.
// A new item is taken only in the idle state, after the last one is fully handled. Reset
// (aresetn, synchronous, active low) empties the queue and the result register.
module async_start_stop_deframer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [assd_pkg::BITS_W-1:0]        s_new_bits,
    input  logic [assd_pkg::COUNT_W-1:0]       s_bit_count_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [assd_pkg::CHAR_W-1:0]        m_char_out,
    output logic                               m_stop_ok
);

    localparam int unsigned QW = assd_pkg::QUEUE_W;
    localparam int unsigned PW = assd_pkg::PEND_W;
    localparam int unsigned CW = assd_pkg::COUNT_W;
    localparam int unsigned IW = assd_pkg::IDX_W;

    assd_pkg::state_t state_reg, state_next;

    // Queue: oldest pending bit sits at the top, bit QW-1.
    logic [QW-1:0]                  q_reg, q_next;
    logic [PW-1:0]                  pend_reg, pend_next;
    logic [assd_pkg::BITS_W-1:0]    bits_reg, bits_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;

    logic                           out_valid_reg, out_valid_next;
    logic [assd_pkg::CHAR_W-1:0]    char_reg, char_next;
    logic                           stop_reg, stop_next;

    logic                           drop;
    logic [QW-1:0]                  q_shift;
    logic [PW-1:0]                  pend_drop;
    logic [PW-1:0]                  wr_pos;
    logic                           have_bit;
    logic                           line_bit;
    logic                           append;
    logic [IW-1:0]                  bit_idx;
    logic [CW-1:0]                  count_sat;
    logic                           out_free;
    logic [assd_pkg::CHAR_W-1:0]    frame_char;

    assign s_ready    = (state_reg == assd_pkg::ST_IDLE);
    assign m_valid    = out_valid_reg;
    assign m_char_out = char_reg;
    assign m_stop_ok  = stop_reg;

    assign out_free = !out_valid_reg || m_ready;

    // Counts above the maximum are clamped.
    assign count_sat = (s_bit_count_in > CW'(assd_pkg::MAX_BITS_PER_CALL))
                     ? CW'(assd_pkg::MAX_BITS_PER_CALL) : s_bit_count_in;

    // One step of the queue: drop an idle one at the old end, append the next line bit.
    assign drop      = (pend_reg != '0) && q_reg[QW-1];
    assign q_shift   = drop ? {q_reg[QW-2:0], 1'b0} : q_reg;
    assign pend_drop = drop ? pend_reg - PW'(1) : pend_reg;
    assign have_bit  = (cnt_reg != '0);
    assign bit_idx   = IW'(cnt_reg - CW'(1));
    assign line_bit  = bits_reg[bit_idx];
    assign append    = have_bit && !((pend_drop == '0) && line_bit);
    assign wr_pos    = PW'(QW - 1) - pend_drop;

    // Data bits follow the start bit, least significant first.
    always_comb begin
        for (int i = 0; i < assd_pkg::CHAR_W; i++) begin
            frame_char[i] = q_reg[QW-2-i];
        end
    end

    // Sequencer and datapath next values.
    always_comb begin
        state_next     = state_reg;
        q_next         = q_reg;
        pend_next      = pend_reg;
        bits_next      = bits_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        stop_next      = stop_reg;

        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            assd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    bits_next  = s_new_bits;
                    cnt_next   = count_sat;
                    state_next = assd_pkg::ST_RUN;
                end
            end
            assd_pkg::ST_RUN: begin
                if (!have_bit && !drop) begin
                    if (pend_reg >= PW'(assd_pkg::FRAME_BITS)) begin
                        state_next = assd_pkg::ST_EMIT;
                    end else begin
                        state_next = assd_pkg::ST_IDLE;
                    end
                end else begin
                    for (int i = 0; i < QW; i++) begin
                        q_next[i] = (append && (wr_pos == PW'(i))) ? line_bit : q_shift[i];
                    end
                    pend_next = pend_drop + PW'(append);
                    if (have_bit) begin
                        cnt_next = cnt_reg - CW'(1);
                    end
                end
            end
            assd_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    char_next      = frame_char;
                    stop_next      = q_reg[QW-1-assd_pkg::FRAME_BITS+1];
                    q_next         = q_reg << assd_pkg::FRAME_BITS;
                    pend_next      = pend_reg - PW'(assd_pkg::FRAME_BITS);
                    state_next     = assd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = assd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= assd_pkg::ST_IDLE;
            pend_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        q_reg    <= q_next;
        bits_reg <= bits_next;
        char_reg <= char_next;
        stop_reg <= stop_next;
    end

    // The queue never holds more bits than it has room for.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= PW'(QW))
        else $error("queue fill exceeds its size");

    // Between items, less than a full frame is left pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == assd_pkg::ST_IDLE) |-> (pend_reg < PW'(assd_pkg::FRAME_BITS)))
        else $error("full frame left pending while idle");

    // A frame is emitted only with a zero start bit at the old end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == assd_pkg::ST_EMIT) |->
            (!q_reg[QW-1] && (pend_reg >= PW'(assd_pkg::FRAME_BITS))))
        else $error("frame emitted without start bit or enough bits");

    // A blocked result register holds the sequencer in its emit step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == assd_pkg::ST_EMIT) && out_valid_reg && !m_ready) |=>
            (state_reg == assd_pkg::ST_EMIT))
        else $error("frame left emit step while result register was full");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the start/stop serial receive deframer.
module tb;

    localparam int unsigned BITS_W            = assd_pkg::BITS_W;
    localparam int unsigned COUNT_W           = assd_pkg::COUNT_W;
    localparam int unsigned CHAR_W            = assd_pkg::CHAR_W;
    localparam int unsigned MAX_BITS_PER_CALL = assd_pkg::MAX_BITS_PER_CALL;
    localparam int unsigned FRAME_BITS        = assd_pkg::FRAME_BITS;

    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned TARGET_ITEMS  = 1075;
    localparam int unsigned IDLE_PERCENT  = 17;
    localparam int unsigned HOLD_AT_ITEM  = 300;
    localparam int unsigned HOLD_CYCLES   = 250;
    localparam int unsigned BUSY_FROM     = 500;
    localparam int unsigned BUSY_TO       = 700;
    localparam int unsigned SETTLE_CYCLES = 40;

    typedef struct {
        logic [BITS_W-1:0]  bits;
        logic [COUNT_W-1:0] count;
        logic               wait_drain;
    } group_t;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              stop_ok;
    } char_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [BITS_W-1:0]   s_new_bits = '0;
    logic [COUNT_W-1:0]  s_bit_count_in = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CHAR_W-1:0]   m_char_out;
    logic                m_stop_ok;

    group_t      offered_groups[$];
    char_t       expected_chars[$];
    bit          line_bits[$];

    // Mirror of the deframer state: bit queue with newest bit at position 0.
    logic [17:0] rx_sr = '0;
    int unsigned rx_pend = 0;

    int unsigned errors = 0;
    int unsigned accepted_groups = 0;
    int unsigned chars_seen = 0;
    int unsigned framing_errors = 0;
    int unsigned cycles = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          group_taken = 1'b0;

    async_start_stop_deframer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_new_bits     (s_new_bits),
        .s_bit_count_in (s_bit_count_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_char_out     (m_char_out),
        .m_stop_ok      (m_stop_ok)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Appends one group to the mirrored queue; returns 1 when a character comes out.
    function automatic bit deframe_group(input logic [BITS_W-1:0] bits,
                                         input logic [COUNT_W-1:0] count,
                                         output char_t result);
        int unsigned n;
        logic [7:0]  data;
        n = (count > MAX_BITS_PER_CALL) ? MAX_BITS_PER_CALL : count;
        rx_sr = (rx_sr << n) | 18'(bits & ((9'd1 << n) - 9'd1));
        rx_pend += n;
        // Idle ones at the old end of the queue are dropped.
        while (rx_pend > 0 && rx_sr[rx_pend-1])
            rx_pend--;
        if (rx_pend < FRAME_BITS)
            return 1'b0;
        data = rx_sr[rx_pend-2 -: 8];
        // Data bits arrive least significant first, so the oldest goes to bit 0.
        for (int i = 0; i < 8; i++)
            result.ch[i] = data[7-i];
        result.stop_ok = rx_sr[rx_pend-FRAME_BITS];
        rx_pend -= FRAME_BITS;
        return 1'b1;
    endfunction

    task automatic add_group(input logic [BITS_W-1:0] bits, input logic [COUNT_W-1:0] count);
        group_t g;
        g.bits = bits;
        g.count = count;
        g.wait_drain = 1'b0;
        offered_groups.push_back(g);
    endtask

    task automatic push_idle(input int unsigned k);
        repeat (k) line_bits.push_back(1'b1);
    endtask

    task automatic push_frame(input logic [7:0] ch, input bit stop);
        line_bits.push_back(1'b0);
        for (int i = 0; i < 8; i++)
            line_bits.push_back(ch[i]);
        line_bits.push_back(stop);
    endtask

    // Takes n line bits (idle ones once the line runs dry), oldest into bit n-1.
    task automatic take_line(input int unsigned n, input logic [COUNT_W-1:0] count);
        logic [BITS_W-1:0] bits;
        bit                b;
        bits = '0;
        for (int i = 0; i < n; i++) begin
            b = (line_bits.size() != 0) ? line_bits.pop_front() : 1'b1;
            bits = {bits[BITS_W-2:0], b};
        end
        // Unused upper positions carry random junk.
        if (n < BITS_W)
            bits |= 8'($urandom) & ~((8'd1 << n) - 8'd1);
        add_group(bits, count);
    endtask

    // Clock counter and timeout.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d characters still expected", $time,
                     expected_chars.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Monitor: checks characters and records accepted groups.
    always @(posedge aclk) begin
        char_t want;
        char_t got;
        if (aresetn && m_valid && m_ready) begin
            chars_seen++;
            if (!m_stop_ok)
                framing_errors++;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character: got char %02h stop_ok %0b",
                         $time, m_char_out, m_stop_ok);
                errors++;
            end else begin
                want = expected_chars.pop_front();
                if (m_char_out !== want.ch) begin
                    $display("%0t: char_out mismatch: expected %02h got %02h",
                             $time, want.ch, m_char_out);
                    errors++;
                end
                if (m_stop_ok !== want.stop_ok) begin
                    $display("%0t: stop_ok mismatch: expected %0b got %0b",
                             $time, want.stop_ok, m_stop_ok);
                    errors++;
                end
            end
        end
        group_taken = aresetn && s_valid && s_ready;
        if (group_taken) begin
            accepted_groups++;
            if (deframe_group(s_new_bits, s_bit_count_in, got))
                expected_chars.push_back(got);
        end
    end

    // Driver: offers queued groups, with random gaps and drain pauses.
    always @(negedge aclk) begin
        logic              next_valid;
        logic [BITS_W-1:0] next_bits;
        logic [COUNT_W-1:0] next_count;
        bit                busy_stretch;
        group_t            g;
        next_valid = s_valid;
        next_bits = s_new_bits;
        next_count = s_bit_count_in;
        busy_stretch = accepted_groups >= BUSY_FROM && accepted_groups < BUSY_TO;
        if (aresetn && (!s_valid || group_taken)) begin
            next_valid = 1'b0;
            if (offered_groups.size() != 0 &&
                !(offered_groups[0].wait_drain && expected_chars.size() != 0) &&
                (busy_stretch || $urandom_range(99, 0) >= IDLE_PERCENT)) begin
                g = offered_groups.pop_front();
                next_valid = 1'b1;
                next_bits = g.bits;
                next_count = g.count;
            end
        end
        s_valid <= next_valid;
        s_new_bits <= next_bits;
        s_bit_count_in <= next_count;
    end

    // Receiver: random stalls, one long hold-off, and a stretch with no stalls.
    always @(negedge aclk) begin
        logic next_ready;
        if (hold_left != 0) begin
            hold_left--;
            next_ready = 1'b0;
        end else if (!hold_done && accepted_groups >= HOLD_AT_ITEM) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            next_ready = 1'b0;
        end else if (accepted_groups >= BUSY_FROM && accepted_groups < BUSY_TO) begin
            next_ready = 1'b1;
        end else begin
            next_ready = $urandom_range(99, 0) >= IDLE_PERCENT;
        end
        m_ready <= next_ready;
    end

    // Stimulus and end of run.
    initial begin
        int unsigned n;
        int unsigned r;
        logic [COUNT_W-1:0] count;

        // Zero-count groups right after reset, then an all-idle group.
        add_group(8'hFF, 4'd0);
        add_group(8'h00, 4'd0);
        push_idle(8);
        take_line(8, 4'd8);
        // All-zero character, count above the maximum.
        push_frame(8'h00, 1'b1);
        take_line(8, 4'd15);
        take_line(2, 4'd2);
        // All-ones character.
        push_frame(8'hFF, 1'b1);
        take_line(5, 4'd5);
        take_line(5, 4'd5);
        // Bad stop bit.
        push_frame(8'hA5, 1'b0);
        take_line(3, 4'd3);
        take_line(7, 4'd7);
        // Idle ones before a frame, then idle ones left after it.
        push_idle(3);
        push_frame(8'h3C, 1'b1);
        push_idle(2);
        take_line(8, 4'd9);
        take_line(7, 4'd7);
        add_group(8'hFF, 4'd0);
        // Single-bit and two-bit groups.
        push_frame(8'h81, 1'b1);
        take_line(1, 4'd1);
        take_line(1, 4'd1);
        for (int i = 0; i < 4; i++)
            take_line(2, 4'd2);
        // Back-to-back frames, at most one character per group.
        push_frame(8'h5A, 1'b1);
        push_frame(8'hC3, 1'b0);
        take_line(8, 4'd8);
        take_line(8, 4'd12);
        take_line(4, 4'd4);

        // Random part: mostly well-formed frames, some noise and stray groups.
        while (offered_groups.size() < TARGET_ITEMS) begin
            r = $urandom_range(99, 0);
            if (r < 80) begin
                push_idle(($urandom_range(9, 0) == 0) ? $urandom_range(14, 3)
                                                     : $urandom_range(2, 0));
                push_frame(8'($urandom), $urandom_range(9, 0) != 0);
                forever begin
                    n = $urandom_range(MAX_BITS_PER_CALL, 1);
                    if (line_bits.size() < n)
                        break;
                    count = (n == MAX_BITS_PER_CALL && $urandom_range(3, 0) == 0)
                            ? COUNT_W'($urandom_range(15, MAX_BITS_PER_CALL + 1))
                            : COUNT_W'(n);
                    take_line(n, count);
                end
            end else if (r < 95) begin
                add_group(8'($urandom), COUNT_W'($urandom_range(15, 1)));
            end else begin
                add_group(8'($urandom), 4'd0);
            end
            // A few points where the sender waits for the receiver to catch up.
            if (offered_groups.size() % 350 == 0 && offered_groups.size() != 0)
                offered_groups[offered_groups.size()-1].wait_drain = 1'b1;
        end
        take_line(line_bits.size() % 9, COUNT_W'(line_bits.size() % 9));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (offered_groups.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_chars.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (expected_chars.size() != 0) begin
            $display("%0t: %0d characters never arrived", $time, expected_chars.size());
            errors++;
        end
        $display("Sent %0d bit groups, received %0d characters (%0d with a bad stop bit).",
                 accepted_groups, chars_seen, framing_errors);
        $display("Checked in %0d cycles with %0d mismatches.", cycles, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
